// ===== design/assert_macros.svh =====
// assertion macro used by the note mixer datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define SQM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("note mixer assertion failed");

`endif

// ===== design/sqm_pkg.sv =====
// types and constants of the polyphonic square note mixer
package sqm_pkg;

   localparam int NOTE_SLOTS_DEFAULT = 16;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic MIX_RESET = 1'b1;
   localparam logic [11:0] LEVEL_MAX = 12'd4095;

   localparam logic CSR_TIMEOUT_TICKS = 1'b0;
   localparam logic CSR_MIX_MODE = 1'b1;

   typedef enum logic [1:0] {
      OP_NOTE   = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_TICK   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [6:0]  pitch;
      logic [7:0]  intensity;
      logic [15:0] period;
      logic [31:0] sample_time;
   } req_type;

   typedef struct packed {
      logic [11:0] level;
      logic [4:0]  active_notes;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_NOTE_SCAN,
      ST_TICK_SCAN,
      ST_SAMP_SCAN,
      ST_SAMP_DIV,
      ST_SAMP_ACC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic update;
      logic remove;
      logic append;
      logic k_inc;
      logic cd_dec;
      logic div_start;
      logic div_step;
      logic acc_add;
      logic clear;
      logic finish;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   scan_end;
      logic   match;
      logic   cd_zero;
      logic   full;
      logic   inten_zero;
      logic   div_last;
      logic   rsp_free;
   } status_type;

endpackage

// ===== design/sqm_ctrl.sv =====
// controller state machine of the note mixer
module sqm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  sqm_pkg::status_type status,
   output sqm_pkg::cmd_type    cmd
);

   sqm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sqm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = (state_ff != sqm_pkg::ST_IDLE);
      unique case (state_ff)
         sqm_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sqm_pkg::ST_DISPATCH;
            end
         end
         sqm_pkg::ST_DISPATCH: begin
            unique case (status.op)
               sqm_pkg::OP_NOTE:   state_in = sqm_pkg::ST_NOTE_SCAN;
               sqm_pkg::OP_SAMPLE: state_in = sqm_pkg::ST_SAMP_SCAN;
               sqm_pkg::OP_TICK:   state_in = sqm_pkg::ST_TICK_SCAN;
               sqm_pkg::OP_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in = sqm_pkg::ST_DONE;
               end
               default: state_in = sqm_pkg::ST_DONE;
            endcase
         end
         sqm_pkg::ST_NOTE_SCAN: begin
            priority if (status.scan_end) begin
               cmd.append = !status.full && !status.inten_zero;
               state_in = sqm_pkg::ST_DONE;
            end else if (status.match) begin
               cmd.remove = status.inten_zero;
               cmd.update = !status.inten_zero;
               state_in = sqm_pkg::ST_DONE;
            end else begin
               cmd.k_inc = 1'b1;
            end
         end
         sqm_pkg::ST_TICK_SCAN: begin
            priority if (status.scan_end) begin
               state_in = sqm_pkg::ST_DONE;
            end else if (status.cd_zero) begin
               cmd.remove = 1'b1;
            end else begin
               cmd.cd_dec = 1'b1;
               cmd.k_inc = 1'b1;
            end
         end
         sqm_pkg::ST_SAMP_SCAN: begin
            if (status.scan_end) begin
               state_in = sqm_pkg::ST_DONE;
            end else begin
               cmd.div_start = 1'b1;
               state_in = sqm_pkg::ST_SAMP_DIV;
            end
         end
         sqm_pkg::ST_SAMP_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = sqm_pkg::ST_SAMP_ACC;
            end
         end
         sqm_pkg::ST_SAMP_ACC: begin
            cmd.acc_add = 1'b1;
            cmd.k_inc = 1'b1;
            state_in = sqm_pkg::ST_SAMP_SCAN;
         end
         sqm_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in = sqm_pkg::ST_IDLE;
            end
         end
         default: state_in = sqm_pkg::ST_IDLE;
      endcase
   end

endmodule

// ===== design/sqm_datapath.sv =====
// note table, remainder unit, accumulator and output register
`include "assert_macros.svh"

module sqm_datapath #(
   parameter int NOTE_SLOTS = sqm_pkg::NOTE_SLOTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  sqm_pkg::req_type    req_data,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [15:0]         csr_wdata,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sqm_pkg::rsp_type    rsp_data,
   input  sqm_pkg::cmd_type    cmd,
   output sqm_pkg::status_type status
);

   localparam int IDX_W = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
   localparam int CNT_W = $clog2(NOTE_SLOTS + 1);
   localparam int ACC_W = 8 + $clog2(NOTE_SLOTS + 1);
   localparam int SAT_W = (ACC_W > 12) ? ACC_W : 12;

   logic [6:0]  pitch_ff  [NOTE_SLOTS];
   logic [7:0]  inten_ff  [NOTE_SLOTS];
   logic [15:0] period_ff [NOTE_SLOTS];
   logic [15:0] cd_ff     [NOTE_SLOTS];

   sqm_pkg::req_type req_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [15:0] timeout_ff;
   logic        mix_ff;
   logic [15:0] rem_ff;
   logic [4:0]  bit_ff;
   logic [ACC_W-1:0] acc_ff;
   logic        rsp_valid_ff;
   sqm_pkg::rsp_type rsp_ff;

   logic [IDX_W-1:0] kx;
   logic [16:0] shifted;
   logic [15:0] rem_in;
   logic        wave_high;
   logic [7:0]  addend;
   logic [SAT_W-1:0] acc_wide;
   logic [11:0] level_sat;

   assign kx = k_ff[IDX_W-1:0];

   genvar i;
   generate
      for (i = 0; i < NOTE_SLOTS; i++) begin : g_slot
         always_ff @(posedge clock) begin
            if (cmd.remove && (k_ff <= CNT_W'(i))) begin
               if (i < NOTE_SLOTS - 1) begin
                  pitch_ff[i]  <= pitch_ff[(i < NOTE_SLOTS - 1) ? i + 1 : i];
                  inten_ff[i]  <= inten_ff[(i < NOTE_SLOTS - 1) ? i + 1 : i];
                  period_ff[i] <= period_ff[(i < NOTE_SLOTS - 1) ? i + 1 : i];
                  cd_ff[i]     <= cd_ff[(i < NOTE_SLOTS - 1) ? i + 1 : i];
               end
            end else if (cmd.append && (cnt_ff == CNT_W'(i))) begin
               pitch_ff[i]  <= req_ff.pitch;
               inten_ff[i]  <= req_ff.intensity;
               period_ff[i] <= req_ff.period;
               cd_ff[i]     <= timeout_ff;
            end else begin
               if (cmd.update && (k_ff == CNT_W'(i))) begin
                  inten_ff[i] <= req_ff.intensity;
               end
               if (cmd.cd_dec && (k_ff == CNT_W'(i))) begin
                  cd_ff[i] <= cd_ff[i] - 16'd1;
               end
            end
         end
      end
   endgenerate

   always_comb begin
      cnt_in = cnt_ff;
      priority if (cmd.clear) begin
         cnt_in = '0;
      end else if (cmd.remove) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end else if (cmd.append) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
      k_in = k_ff;
      priority if (cmd.load) begin
         k_in = '0;
      end else if (cmd.k_inc) begin
         k_in = k_ff + CNT_W'(1);
      end else begin
         k_in = k_ff;
      end
   end

   // one remainder bit per cycle, msb first
   assign shifted = {rem_ff, req_ff.sample_time[bit_ff]};
   assign rem_in = (shifted >= {1'b0, period_ff[kx]}) ?
                   16'(shifted - {1'b0, period_ff[kx]}) : shifted[15:0];
   assign wave_high = (period_ff[kx] != 16'd0) && (rem_ff < (period_ff[kx] >> 1));
   assign addend = mix_ff ? inten_ff[kx] : {7'd0, (inten_ff[kx] != 8'd0)};
   assign acc_wide = SAT_W'(acc_ff);
   assign level_sat = (acc_wide > SAT_W'(sqm_pkg::LEVEL_MAX)) ?
                      sqm_pkg::LEVEL_MAX : acc_wide[11:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         k_ff <= '0;
         timeout_ff <= sqm_pkg::TIMEOUT_RESET;
         mix_ff <= sqm_pkg::MIX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         k_ff <= k_in;
         if (csr_write) begin
            unique case (csr_index)
               sqm_pkg::CSR_TIMEOUT_TICKS: timeout_ff <= csr_wdata;
               sqm_pkg::CSR_MIX_MODE:      mix_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         priority if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= rsp_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
         acc_ff <= '0;
      end else if (cmd.acc_add && wave_high) begin
         acc_ff <= acc_ff + ACC_W'(addend);
      end
      if (cmd.div_start) begin
         rem_ff <= '0;
         bit_ff <= 5'd31;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         bit_ff <= bit_ff - 5'd1;
      end
      if (cmd.finish) begin
         rsp_ff.level <= level_sat;
         rsp_ff.active_notes <= 5'(cnt_ff);
      end
   end

   always_comb begin
      status.op = req_ff.op;
      status.scan_end = (k_ff >= cnt_ff) || (!mix_ff && req_ff.op == sqm_pkg::OP_SAMPLE
                        && k_ff != '0);
      status.match = (pitch_ff[kx] == req_ff.pitch);
      status.cd_zero = (cd_ff[kx] == 16'd0);
      status.full = (cnt_ff >= CNT_W'(NOTE_SLOTS));
      status.inten_zero = (req_ff.intensity == 8'd0);
      status.div_last = (bit_ff == 5'd0);
      status.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `SQM_ASSERT(a_count_bound, clock, reset, cnt_ff <= CNT_W'(NOTE_SLOTS))
   `SQM_ASSERT(a_append_grows, clock, reset, cmd.append |=> cnt_ff == $past(cnt_ff) + CNT_W'(1))
   `SQM_ASSERT(a_remove_shrinks, clock, reset, cmd.remove |=> cnt_ff == $past(cnt_ff) - CNT_W'(1))
   `SQM_ASSERT(a_clear_empties, clock, reset, cmd.clear |=> cnt_ff == '0)

endmodule

// ===== design/polyphonic_square_note_mixer_core.sv =====
// top level of the polyphonic square note mixer
// note commands and ticks walk the note table, clear empties it, and a sample walks the notes
// through the remainder unit (basic mode walks at most the first note)
// one transaction in flight; the 32-step remainder unit per note sets the sample rate
// a finished result waits in the output register while the next request is taken
// synchronous reset empties the table and restores timeout_ticks 1000 and mix_mode 1
module polyphonic_square_note_mixer_core #(
   parameter int NOTE_SLOTS = sqm_pkg::NOTE_SLOTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sqm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sqm_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata
);

   sqm_pkg::cmd_type    cmd;
   sqm_pkg::status_type status;

   sqm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sqm_datapath #(
      .NOTE_SLOTS (NOTE_SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== tb/sv/polyphonic_square_note_mixer_core_test.sv =====
// testbench of the polyphonic square note mixer core: scoreboard, drivers and checks
module polyphonic_square_note_mixer_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 16;
   localparam int CYCLE_LIMIT = 3000000;

   class mixer_scoreboard;
      logic [6:0]  tab_pitch[SLOTS];
      logic [7:0]  tab_inten[SLOTS];
      logic [15:0] tab_period[SLOTS];
      logic [15:0] tab_count[SLOTS];
      int          notes;
      logic [15:0] timeout;
      logic        mix;
      sqm_pkg::rsp_type pending[$];
      int          mismatches;
      int          checked;
      int          notes_peak;

      function new();
         notes = 0;
         timeout = sqm_pkg::TIMEOUT_RESET;
         mix = sqm_pkg::MIX_RESET;
         mismatches = 0;
         checked = 0;
         notes_peak = 0;
      endfunction

      function void drop(int at);
         for (int k = at; k + 1 < notes; k++) begin
            tab_pitch[k] = tab_pitch[k + 1];
            tab_inten[k] = tab_inten[k + 1];
            tab_period[k] = tab_period[k + 1];
            tab_count[k] = tab_count[k + 1];
         end
         notes--;
      endfunction

      function bit high_half(logic [15:0] per, logic [31:0] t);
         if (per == 0) return 0;
         return (t % {16'd0, per}) < {16'd0, per >> 1};
      endfunction

      function void note_request(sqm_pkg::req_type r);
         sqm_pkg::rsp_type e;
         int acc;
         int k;
         bit hit;
         acc = 0;
         hit = 0;
         case (r.op)
            sqm_pkg::OP_NOTE: begin
               for (k = 0; k < notes && !hit; k++) begin
                  if (tab_pitch[k] == r.pitch) begin
                     hit = 1;
                     if (r.intensity == 0) drop(k);
                     else tab_inten[k] = r.intensity;
                  end
               end
               if (!hit && notes < SLOTS && r.intensity != 0) begin
                  tab_pitch[notes] = r.pitch;
                  tab_inten[notes] = r.intensity;
                  tab_period[notes] = r.period;
                  tab_count[notes] = timeout;
                  notes++;
               end
            end
            sqm_pkg::OP_SAMPLE: begin
               if (notes != 0) begin
                  if (!mix) begin
                     acc = int'(tab_inten[0] != 0 && high_half(tab_period[0], r.sample_time));
                  end else begin
                     for (k = 0; k < notes; k++)
                        if (high_half(tab_period[k], r.sample_time))
                           acc += int'(tab_inten[k]);
                     if (acc > int'(sqm_pkg::LEVEL_MAX)) acc = int'(sqm_pkg::LEVEL_MAX);
                  end
               end
            end
            sqm_pkg::OP_TICK: begin
               k = 0;
               while (k < notes) begin
                  if (tab_count[k] == 0) drop(k);
                  else begin
                     tab_count[k]--;
                     k++;
                  end
               end
            end
            default: notes = 0;
         endcase
         if (notes > notes_peak) notes_peak = notes;
         e.level = acc[11:0];
         e.active_notes = notes[4:0];
         pending.push_back(e);
      endfunction

      function void check_response(sqm_pkg::rsp_type got);
         sqm_pkg::rsp_type e;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
         end
         e = pending.pop_front();
         if (got.level !== e.level || got.active_notes !== e.active_notes) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected level %0d notes %0d, got level %0d notes %0d",
                        e.level, e.active_notes, got.level, got.active_notes);
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   sqm_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   sqm_pkg::rsp_type rsp_data;
   logic    csr_write = 0;
   logic    csr_index = 0;
   logic [15:0] csr_wdata = 0;

   mixer_scoreboard board = new();
   int cycles = 0;
   int sent = 0;
   int stall_mode = 0;
   logic [6:0] pool[8];

   polyphonic_square_note_mixer_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
      case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
      if ($urandom_range(0, 199) == 0) stall_mode <= int'($urandom_range(0, 2));
   end

   task automatic send(sqm_pkg::req_type r);
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
      sent++;
      if ($urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (3 + 34 * SLOTS + 20) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 0;
      if (idx == sqm_pkg::CSR_TIMEOUT_TICKS) board.timeout = val;
      else board.mix = val[0];
      @(posedge clock);
   endtask

   function automatic sqm_pkg::req_type make(sqm_pkg::op_type op, logic [6:0] p,
                                             logic [7:0] i, logic [15:0] per,
                                             logic [31:0] t);
      sqm_pkg::req_type r;
      r.op = op;
      r.pitch = p;
      r.intensity = i;
      r.period = per;
      r.sample_time = t;
      return r;
   endfunction

   function automatic sqm_pkg::req_type random_item(int shaped);
      sqm_pkg::req_type r;
      int pick;
      r = make(sqm_pkg::OP_NOTE, 7'd0, 8'd0, 16'd0, 32'd0);
      r.pitch = shaped ? pool[$urandom_range(0, 7)] : 7'($urandom_range(0, 127));
      r.intensity = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      pick = int'($urandom_range(0, 9));
      r.period = (pick == 0) ? 16'hffff : (pick == 1) ? 16'($urandom_range(0, 3))
                 : (pick < 6) ? 16'($urandom_range(2, 64)) : 16'($urandom_range(0, 65535));
      r.sample_time = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 300);
      pick = int'($urandom_range(0, 99));
      if (pick < 45) r.op = sqm_pkg::OP_NOTE;
      else if (pick < 80) r.op = sqm_pkg::OP_SAMPLE;
      else if (pick < 97) r.op = sqm_pkg::OP_TICK;
      else r.op = sqm_pkg::OP_CLEAR;
      return r;
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed items
      send(make(sqm_pkg::OP_SAMPLE, 0, 0, 0, 0));
      send(make(sqm_pkg::OP_NOTE, 7'd0, 8'd255, 16'd4, 0));
      send(make(sqm_pkg::OP_NOTE, 7'd127, 8'd1, 16'hffff, 0));
      send(make(sqm_pkg::OP_NOTE, 7'd5, 8'd0, 16'd2, 0));
      send(make(sqm_pkg::OP_NOTE, 7'd9, 8'd10, 16'd0, 0));
      send(make(sqm_pkg::OP_SAMPLE, 0, 0, 0, 32'd1));
      send(make(sqm_pkg::OP_SAMPLE, 0, 0, 0, 32'hffffffff));
      send(make(sqm_pkg::OP_NOTE, 7'd0, 8'd128, 16'd99, 0));
      send(make(sqm_pkg::OP_SAMPLE, 0, 0, 0, 32'd0));
      send(make(sqm_pkg::OP_NOTE, 7'd127, 8'd0, 0, 0));
      send(make(sqm_pkg::OP_TICK, 0, 0, 0, 0));
      for (int k = 0; k < 16; k++)
         send(make(sqm_pkg::OP_NOTE, 7'(k + 20), 8'd255, 16'd2, 0));
      send(make(sqm_pkg::OP_SAMPLE, 0, 0, 0, 32'd0));
      send(make(sqm_pkg::OP_CLEAR, 0, 0, 0, 0));
      drain();
      write_reg(sqm_pkg::CSR_TIMEOUT_TICKS, 16'd0);
      write_reg(sqm_pkg::CSR_MIX_MODE, 16'd0);
      send(make(sqm_pkg::OP_NOTE, 7'd3, 8'd0, 16'd2, 0));
      send(make(sqm_pkg::OP_NOTE, 7'd3, 8'd7, 16'd2, 0));
      send(make(sqm_pkg::OP_SAMPLE, 0, 0, 0, 32'd0));
      send(make(sqm_pkg::OP_TICK, 0, 0, 0, 0));
      // random phases
      for (int ph = 0; ph < 9; ph++) begin
         drain();
         case (ph)
            0: write_reg(sqm_pkg::CSR_TIMEOUT_TICKS, 16'hffff);
            1: write_reg(sqm_pkg::CSR_TIMEOUT_TICKS, 16'd3);
            2: write_reg(sqm_pkg::CSR_TIMEOUT_TICKS, 16'd0);
            default: write_reg(sqm_pkg::CSR_TIMEOUT_TICKS, 16'($urandom_range(0, 20)));
         endcase
         write_reg(sqm_pkg::CSR_MIX_MODE, ((ph % 3) != 0) ? 16'd1 : 16'd0);
         for (int k = 0; k < 8; k++) pool[k] = 7'($urandom_range(0, 127));
         for (int n = 0; n < 150; n++) send(random_item(int'($urandom_range(0, 9) < 8)));
      end
      drain();
      $display("sent %0d requests, checked %0d responses, table reached %0d notes",
               sent, board.checked, board.notes_peak);
      $display("covered add, update, remove, ticks, clears and both mix modes");
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
